// ----- rtl/core/hdrtm_pkg.sv -----
// Shared constants, pipeline stage types and fixed-point helpers for the
// HDR to SDR tone map block. No dependencies.
package hdrtm_pkg;

  localparam int FRAC_BITS = 12;
  localparam int IN_W      = 24;
  localparam int CFG_W     = 14;
  localparam int KNEE_W    = 12;
  localparam int X_W       = 37;   // scaled channel, Q25.12 worst case
  localparam int Q_W       = 30;   // Q0.30 quotient and search width
  localparam int S_W       = 16;   // square root width
  localparam int L_W       = 16;   // Q0.16 shoulder output
  localparam int CODE_W    = 8;

  localparam int DIV1_STEPS = X_W;
  localparam int DIV2_STEPS = Q_W;
  localparam int SQRT_STEPS = S_W;
  localparam int SRCH_STEPS = 4 * Q_W;
  localparam int POST_STEPS = 3;
  localparam int CHAN_LAT   = 1 + DIV1_STEPS + DIV2_STEPS + SQRT_STEPS + 1
                              + SRCH_STEPS + POST_STEPS + 1 + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SDR_WHITE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_WHITE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_WHITE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 2'd3;

  typedef struct packed {
    logic [X_W-1:0]    rem;
    logic [Q_W-1:0]    q;
    logic [X_W-1:0]    x;
    logic              ident;
    logic [KNEE_W-1:0] xl;
  } div2_t;

  typedef struct packed {
    logic [Q_W-1:0]    r;
    logic [S_W-1:0]    s;
    logic              ident;
    logic [KNEE_W-1:0] xl;
  } sqrt_t;

  typedef struct packed {
    logic [Q_W-1:0] u;
    logic [Q_W-1:0] c;
    logic [Q_W-1:0] p;
    logic [L_W-1:0] l;
  } srch_t;

  typedef struct packed {
    logic [Q_W-1:0] u;
    logic [Q_W-1:0] a;
    logic [Q_W-1:0] b;
    logic [L_W-1:0] l;
  } post_t;

  function automatic logic [Q_W-1:0] mul_q30(input logic [Q_W-1:0] a,
                                             input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b};
    return p[2*Q_W-1:Q_W];
  endfunction

endpackage

// ----- rtl/core/hdr_to_sdr_pixel_tone_map_top.sv -----
// Tone map top level: configuration registers, valid pipeline, alpha path and
// three color channels. Depends on hdrtm_pkg and hdrtm_chan.
//
// One pixel can enter every clock while the output is not stalled. Its result
// passes the bit-per-stage exposure divide (37), knee divide (30), square root
// (16) and the four-multiply-per-bit sRGB power search (120) plus the product,
// shoulder, power and encode stages. A stall on a valid output freezes the
// whole pipeline, and the input stall follows it in the same cycle. Configuration
// is read live by the stages, so write it only while no pixel is in flight.
module hdr_to_sdr_pixel_tone_map_top import hdrtm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [IN_W-1:0] in_red_linear,
  input  logic signed [IN_W-1:0] in_green_linear,
  input  logic signed [IN_W-1:0] in_blue_linear,
  input  logic signed [IN_W-1:0] in_alpha_linear,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CODE_W-1:0]    out_red_srgb,
  output logic [CODE_W-1:0]    out_green_srgb,
  output logic [CODE_W-1:0]    out_blue_srgb,
  output logic [CODE_W-1:0]    out_alpha_byte
);

  logic [CFG_W-1:0]  sdr_white_r;
  logic [CFG_W-1:0]  def_white_r;
  logic [CFG_W-1:0]  ref_white_r;
  logic [KNEE_W-1:0] knee_r;
  logic [CFG_W-1:0]  white;
  logic              en;
  logic              accept;
  logic [CHAN_LAT-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdr_white_r <= CFG_W'(80);
      def_white_r <= CFG_W'(80);
      ref_white_r <= CFG_W'(80);
      knee_r      <= KNEE_W'(3072);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SDR_WHITE: sdr_white_r <= cfg_wdata;
        REG_DEF_WHITE: def_white_r <= cfg_wdata;
        REG_REF_WHITE: ref_white_r <= cfg_wdata;
        REG_KNEE:      knee_r      <= cfg_wdata[KNEE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sdr_white_r != '0) begin
      white = sdr_white_r;
    end else if (def_white_r != '0) begin
      white = def_white_r;
    end else begin
      white = CFG_W'(1);
    end
  end

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign out_valid = v_r[CHAN_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[CHAN_LAT-2:0], in_valid};
    end
  end

  hdrtm_chan u_red (
    .clk(clk), .en(en), .lin(in_red_linear), .ref_white(ref_white_r),
    .white(white), .knee(knee_r), .code(out_red_srgb)
  );

  hdrtm_chan u_green (
    .clk(clk), .en(en), .lin(in_green_linear), .ref_white(ref_white_r),
    .white(white), .knee(knee_r), .code(out_green_srgb)
  );

  hdrtm_chan u_blue (
    .clk(clk), .en(en), .lin(in_blue_linear), .ref_white(ref_white_r),
    .white(white), .knee(knee_r), .code(out_blue_srgb)
  );

  // Alpha is done in the first stage and then delayed to line up with color.
  localparam logic [FRAC_BITS:0] ALPHA_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [FRAC_BITS:0]        a_clamp;
  logic [FRAC_BITS+8:0]      a_prod;
  logic [CODE_W-1:0]         a_r [0:CHAN_LAT-1];

  always_comb begin
    if (in_alpha_linear[IN_W-1]) begin
      a_clamp = '0;
    end else if (in_alpha_linear[IN_W-2:0] > (IN_W-1)'(ALPHA_ONE)) begin
      a_clamp = ALPHA_ONE;
    end else begin
      a_clamp = in_alpha_linear[FRAC_BITS:0];
    end
  end

  assign a_prod = {8'b0, a_clamp} * (FRAC_BITS+9)'(255)
                  + ((FRAC_BITS+9)'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= a_prod[FRAC_BITS+7:FRAC_BITS];
      for (int i = 1; i < CHAN_LAT; i++) begin
        a_r[i] <= a_r[i-1];
      end
    end
  end

  assign out_alpha_byte = a_r[CHAN_LAT-1];

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v_r[0])
    else $error("accepted request did not enter the pipeline");

  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !in_valid) |=> !v_r[0])
    else $error("pipeline gained a request without an input");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> v_r == $past(v_r))
    else $error("valid pipeline moved while stalled");

endmodule

// ----- rtl/core/hdrtm_chan.sv -----
// One color channel of the tone map: exposure divide, shoulder, sRGB encode.
// Depends on hdrtm_pkg; all stages advance together on en.
module hdrtm_chan import hdrtm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   lin,
  input  logic [CFG_W-1:0]  ref_white,
  input  logic [CFG_W-1:0]  white,
  input  logic [KNEE_W-1:0] knee,
  output logic [CODE_W-1:0] code
);

  // Exposure: product, then restoring divide by the white level.
  logic [CFG_W-1:0] d1_rem_r [0:DIV1_STEPS];
  logic [X_W-1:0]   d1_nq_r  [0:DIV1_STEPS];
  logic [IN_W-2:0]  pos;
  logic [X_W-1:0]   n_nxt;

  assign pos   = lin[IN_W-1] ? '0 : lin[IN_W-2:0];
  assign n_nxt = {{(X_W-IN_W+1){1'b0}}, pos} * {{(X_W-CFG_W){1'b0}}, ref_white};

  always_ff @(posedge clk) begin
    if (en) begin
      d1_rem_r[0] <= '0;
      d1_nq_r[0]  <= n_nxt;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DIV1_STEPS; gi++) begin : g_div1
      logic [CFG_W:0]   t;
      logic             ge;
      logic [CFG_W:0]   diff;
      assign t    = {d1_rem_r[gi], d1_nq_r[gi][X_W-1]};
      assign ge   = t >= {1'b0, white};
      assign diff = t - {1'b0, white};
      always_ff @(posedge clk) begin
        if (en) begin
          d1_rem_r[gi+1] <= ge ? diff[CFG_W-1:0] : t[CFG_W-1:0];
          d1_nq_r[gi+1]  <= {d1_nq_r[gi][X_W-2:0], ge};
        end
      end
    end
  endgenerate

  // Shoulder: r = (knee << 30) / x. The quotient fits Q0.30 whenever x > knee.
  div2_t d2_in;
  div2_t d2_r [1:DIV2_STEPS];
  logic [X_W-1:0] x;
  assign x = d1_nq_r[DIV1_STEPS];

  always_comb begin
    d2_in.rem   = {{(X_W-KNEE_W){1'b0}}, knee};
    d2_in.q     = '0;
    d2_in.x     = x;
    d2_in.ident = x <= {{(X_W-KNEE_W){1'b0}}, knee};
    d2_in.xl    = x[KNEE_W-1:0];
  end

  generate
    for (gi = 0; gi < DIV2_STEPS; gi++) begin : g_div2
      div2_t          src;
      div2_t          nxt;
      logic [X_W:0]   t;
      logic [X_W:0]   diff;
      logic           ge;
      if (gi == 0) begin : g_first
        assign src = d2_in;
      end else begin : g_rest
        assign src = d2_r[gi];
      end
      assign t    = {src.rem, 1'b0};
      assign ge   = t >= {1'b0, src.x};
      assign diff = t - {1'b0, src.x};
      always_comb begin
        nxt     = src;
        nxt.rem = ge ? diff[X_W-1:0] : t[X_W-1:0];
        nxt.q   = {src.q[Q_W-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en) begin
          d2_r[gi+1] <= nxt;
        end
      end
    end
  endgenerate

  sqrt_t sq_in;
  sqrt_t sq_r [1:SQRT_STEPS];

  always_comb begin
    sq_in.r     = d2_r[DIV2_STEPS].q;
    sq_in.s     = '0;
    sq_in.ident = d2_r[DIV2_STEPS].ident;
    sq_in.xl    = d2_r[DIV2_STEPS].xl;
  end

  generate
    for (gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
      localparam int BIT = SQRT_STEPS - 1 - gi;
      sqrt_t             src;
      sqrt_t             nxt;
      logic [S_W-1:0]    c;
      logic [2*S_W-1:0]  cc;
      if (gi == 0) begin : g_first
        assign src = sq_in;
      end else begin : g_rest
        assign src = sq_r[gi];
      end
      assign c  = src.s | (S_W'(1) << BIT);
      assign cc = {{S_W{1'b0}}, c} * {{S_W{1'b0}}, c};
      always_comb begin
        nxt = src;
        if (cc <= {{(2*S_W-Q_W){1'b0}}, src.r}) begin
          nxt.s = c;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[gi+1] <= nxt;
        end
      end
    end
  endgenerate

  // Shoulder output L in Q0.16.
  sqrt_t           sq_last;
  logic [12:0]     span;
  logic [28:0]     sprod;
  logic [17:0]     lsub;
  logic [L_W-1:0]  l_nxt;
  logic [L_W-1:0]  l_r;

  assign sq_last = sq_r[SQRT_STEPS];
  assign span    = 13'd4096 - {1'b0, knee};
  assign sprod   = {16'b0, span} * {13'b0, sq_last.s} + 29'd1024;
  assign lsub    = 18'd65536 - sprod[28:11];

  always_comb begin
    if (sq_last.ident) begin
      l_nxt = L_W'({4'b0, sq_last.xl} << (L_W - FRAC_BITS));
    end else if (lsub[17:16] != 2'b00) begin
      l_nxt = '1;
    end else begin
      l_nxt = lsub[L_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= l_nxt;
    end
  end

  // Bit search for u with u^12 <= L, four multiplier stages per bit.
  srch_t sr_in;
  srch_t sr_r [1:SRCH_STEPS];

  always_comb begin
    sr_in   = '0;
    sr_in.l = l_r;
  end

  generate
    for (gi = 0; gi < SRCH_STEPS; gi++) begin : g_srch
      localparam int PHASE = gi % 4;
      localparam int BIT   = Q_W - 1 - gi / 4;
      srch_t src;
      srch_t nxt;
      if (gi == 0) begin : g_first
        assign src = sr_in;
      end else begin : g_rest
        assign src = sr_r[gi];
      end
      always_comb begin
        logic [Q_W-1:0] cand;
        logic [Q_W-1:0] p12;
        nxt  = src;
        cand = src.u | (Q_W'(1) << BIT);
        p12  = mul_q30(src.p, src.p);
        case (PHASE)
          0: begin
            nxt.c = cand;
            nxt.p = mul_q30(cand, cand);
          end
          1: nxt.p = mul_q30(src.p, src.c);
          2: nxt.p = p12;
          default: begin
            if (p12 <= {src.l, 14'b0}) begin
              nxt.u = src.c;
            end
          end
        endcase
      end
      always_ff @(posedge clk) begin
        if (en) begin
          sr_r[gi+1] <= nxt;
        end
      end
    end
  endgenerate

  // p = u^5 through three multiplier stages.
  post_t po_r [1:POST_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      po_r[1].u <= sr_r[SRCH_STEPS].u;
      po_r[1].a <= mul_q30(sr_r[SRCH_STEPS].u, sr_r[SRCH_STEPS].u);
      po_r[1].b <= '0;
      po_r[1].l <= sr_r[SRCH_STEPS].l;
      po_r[2].u <= po_r[1].u;
      po_r[2].a <= po_r[1].a;
      po_r[2].b <= mul_q30(po_r[1].a, po_r[1].u);
      po_r[2].l <= po_r[1].l;
      po_r[3].u <= po_r[2].u;
      po_r[3].a <= po_r[2].a;
      po_r[3].b <= mul_q30(po_r[2].b, po_r[2].a);
      po_r[3].l <= po_r[2].l;
    end
  end

  logic [49:0]     scl_r;
  logic [L_W-1:0]  lf_r;

  always_ff @(posedge clk) begin
    if (en) begin
      scl_r <= {20'b0, po_r[3].b} * 50'd269025 + (50'd500 << Q_W);
      lf_r  <= po_r[3].l;
    end
  end

  localparam logic [49:0] NEG_OFS = 50'd14025 << Q_W;

  logic [49:0]       diffv;
  logic [19:0]       v;
  logic [35:0]       recip;
  logic [22:0]       lin_a;
  logic [13:0]       lin_q;
  logic [CODE_W-1:0] code_nxt;

  assign diffv = scl_r - NEG_OFS;
  assign v     = diffv[Q_W+19:Q_W];
  // Divide by one thousand through a reciprocal; exact for quotients below 256.
  assign recip = {18'b0, v[17:0]} * 36'd268436;
  assign lin_a = {7'b0, lf_r} * 23'd32946 + 23'd327680;
  // Divide by five through a reciprocal; exact for the narrow range here.
  assign lin_q = {8'b0, lin_a[22:17]} * 14'd205;

  always_comb begin
    if (lf_r <= 16'd205) begin
      code_nxt = {4'b0, lin_q[13:10]};
    end else if (scl_r <= NEG_OFS) begin
      code_nxt = '0;
    end else if (v >= 20'd256000) begin
      code_nxt = '1;
    end else begin
      code_nxt = recip[35:28];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code <= code_nxt;
    end
  end

endmodule

// ----- dv/hdrtm_checker.sv -----
// Scoreboard for the HDR to SDR tone map block: follows the register writes,
// predicts each accepted pixel and compares results in order. Depends on hdrtm_pkg.
`timescale 1ns / 100ps
module hdrtm_checker import hdrtm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic signed [IN_W-1:0] in_red_linear,
  input  logic signed [IN_W-1:0] in_green_linear,
  input  logic signed [IN_W-1:0] in_blue_linear,
  input  logic signed [IN_W-1:0] in_alpha_linear,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [CODE_W-1:0]      out_red_srgb,
  input  logic [CODE_W-1:0]      out_green_srgb,
  input  logic [CODE_W-1:0]      out_blue_srgb,
  input  logic [CODE_W-1:0]      out_alpha_byte,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen
);

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
    logic [CODE_W-1:0] alpha;
  } pixel_code_t;

  pixel_code_t expected_codes[$];
  logic [CFG_W-1:0]  sdr_white;
  logic [CFG_W-1:0]  def_white;
  logic [CFG_W-1:0]  ref_white;
  logic [KNEE_W-1:0] knee;

  function automatic longint unsigned clamp_low(logic signed [IN_W-1:0] v);
    return v[IN_W-1] ? 64'd0 : longint'(unsigned'(v));
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned shoulder(longint unsigned x, longint unsigned k);
    longint unsigned r, s, c, l;
    if (x * 4096 <= (k << FRAC_BITS)) return (x << 16) >> FRAC_BITS;
    r = (k << (FRAC_BITS + 18)) / x;
    if (r >= (64'd1 << 30)) r = (64'd1 << 30) - 1;
    s = 0;
    for (int i = 15; i >= 0; i--) begin
      c = s | (64'd1 << i);
      if (c * c <= r) s = c;
    end
    l = 65536 - (((4096 - k) * s + 1024) >> 11);
    return (l > 65535) ? 64'd65535 : l;
  endfunction

  function automatic logic [CODE_W-1:0] encode_srgb(longint unsigned l);
    longint unsigned u, c, c2, c3, c6, p, pos, neg, code;
    if (l <= 205) return CODE_W'((l * 32946 + 327680) / 655360);
    u = 0;
    for (int i = 29; i >= 0; i--) begin
      c  = u | (64'd1 << i);
      c2 = qmul(c, c);
      c3 = qmul(c2, c);
      c6 = qmul(c3, c3);
      if (qmul(c6, c6) <= (l << 14)) u = c;
    end
    c2  = qmul(u, u);
    c3  = qmul(c2, u);
    p   = qmul(c3, c2);
    pos = p * 269025 + 500 * (64'd1 << 30);
    neg = 14025 * (64'd1 << 30);
    if (pos <= neg) return 0;
    code = (pos - neg) / (1000 * (64'd1 << 30));
    return (code > 255) ? 8'd255 : code[7:0];
  endfunction

  function automatic pixel_code_t tone_map(logic signed [IN_W-1:0] r, g, b, a);
    pixel_code_t res;
    longint unsigned white, av;
    white = (sdr_white != 0) ? sdr_white : def_white;
    if (white == 0) white = 1;
    res.red   = encode_srgb(shoulder(clamp_low(r) * ref_white / white, knee));
    res.green = encode_srgb(shoulder(clamp_low(g) * ref_white / white, knee));
    res.blue  = encode_srgb(shoulder(clamp_low(b) * ref_white / white, knee));
    av = clamp_low(a);
    if (av > (64'd1 << FRAC_BITS)) av = 64'd1 << FRAC_BITS;
    res.alpha = CODE_W'((av * 255 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    return res;
  endfunction

  assign pending = expected_codes.size();

  always @(posedge clk) begin
    pixel_code_t want, got;
    if (!rst_n) begin
      sdr_white <= CFG_W'(80);
      def_white <= CFG_W'(80);
      ref_white <= CFG_W'(80);
      knee      <= KNEE_W'(3072);
      expected_codes.delete();
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SDR_WHITE: sdr_white <= cfg_wdata;
          REG_DEF_WHITE: def_white <= cfg_wdata;
          REG_REF_WHITE: ref_white <= cfg_wdata;
          REG_KNEE:      knee      <= cfg_wdata[KNEE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_codes.push_back(tone_map(in_red_linear, in_green_linear,
                                          in_blue_linear, in_alpha_linear));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        got = {out_red_srgb, out_green_srgb, out_blue_srgb, out_alpha_byte};
        if (expected_codes.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_codes.pop_front();
          if (want.red !== got.red || want.green !== got.green ||
              want.blue !== got.blue || want.alpha !== got.alpha) begin
            if (fail_count < 10)
              $display("mismatch rgba exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                       want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/hdr_to_sdr_pixel_tone_map_top_test.sv -----
// Testbench top for the tone map block: clock, reset, register phases, pixel
// stimulus and output back-pressure. Depends on hdrtm_pkg and hdrtm_checker.
`timescale 1ns / 100ps
module hdr_to_sdr_pixel_tone_map_top_test;
  import hdrtm_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_SDR_WHITE;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [IN_W-1:0] in_red_linear = '0;
  logic signed [IN_W-1:0] in_green_linear = '0;
  logic signed [IN_W-1:0] in_blue_linear = '0;
  logic signed [IN_W-1:0] in_alpha_linear = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CODE_W-1:0]      out_red_srgb, out_green_srgb, out_blue_srgb, out_alpha_byte;
  int fail_count, pending, results_seen;
  int cycles = 0;
  int sent = 0;
  bit no_idle = 0;
  bit hold_req = 0;

  hdr_to_sdr_pixel_tone_map_top dut (.*);
  hdrtm_checker scoreboard (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("hdr_to_sdr_pixel_tone_map_top verification failed");
      $finish;
    end
  end

  // Output side: random stall before each result, with a long hold-off in each 380-pixel random run.
  initial begin
    int n;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        n = 600;
        hold_req = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_pixel(logic signed [IN_W-1:0] r, g, b, a);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_red_linear   <= r;
    in_green_linear <= g;
    in_blue_linear  <= b;
    in_alpha_linear <= a;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (250) @(negedge clk);
  endtask

  task automatic write_regs(logic [CFG_W-1:0] sdr, dflt, refw, kn);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_SDR_WHITE; cfg_wdata <= sdr;  @(negedge clk);
    cfg_index <= REG_DEF_WHITE; cfg_wdata <= dflt; @(negedge clk);
    cfg_index <= REG_REF_WHITE; cfg_wdata <= refw; @(negedge clk);
    cfg_index <= REG_KNEE;      cfg_wdata <= kn;   @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] pick_channel();
    case ($urandom_range(0, 9))
      0, 1: return IN_W'($urandom());
      2: return -$signed({1'b0, 23'($urandom_range(1, 70000))});
      3: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return IN_W'($urandom_range(0, 1 << $urandom_range(0, 16)));
    endcase
  endfunction

  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= 100 && i < 160);
      if (i == 200) hold_req = 1;
      send_pixel(pick_channel(), pick_channel(), pick_channel(),
                 $urandom_range(0, 3) == 0 ? pick_channel()
                                           : IN_W'($urandom_range(0, 4200)));
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: zero, extremes, knee boundary, linear segment edge, alpha limits.
    send_pixel(0, 0, 0, 0);
    send_pixel(24'sh7FFFFF, 24'sh800000, -1, 24'sh7FFFFF);
    send_pixel(1, 12, 13, 4096);
    send_pixel(3072, 3073, 3071, 4097);
    send_pixel(4096, 8192, 65536, 2048);
    send_pixel(14, 100, 2000, -1);
    send_pixel(24'sh800000, 1, 24'sh7FFFFF, 24'sh800000);
    write_regs(80, 80, 80, 3072);
    random_pixels(380);
    write_regs(0, 100, 203, 4095);
    send_pixel(3000, 4095, 5000, 1);
    random_pixels(380);
    write_regs(10000, 1, 10000, 1);
    send_pixel(1, 2, 24'sh7FFFFF, 4095);
    random_pixels(380);
    // Both white levels zero and knee zero.
    write_regs(0, 0, 1, 0);
    send_pixel(0, 1, 24'sh7FFFFF, 24'sh7FFFFF);
    send_pixel(-5, 4096, 12, 3);
    random_pixels(380);
    // Knee write with bits above its width.
    write_regs(1, 10000, 10000, 14'h3FFF);
    random_pixels(190);
    write_regs(CFG_W'($urandom_range(0, 10000)), CFG_W'($urandom_range(1, 10000)),
               CFG_W'($urandom_range(1, 10000)), CFG_W'($urandom_range(1, 4095)));
    random_pixels(190);
    drain();
    $display("Sent %0d pixels over six register settings, %0d results checked,", sent,
             results_seen);
    $display("including zero white levels, zero knee and a long output hold-off.");
    if (fail_count == 0) begin
      $display("hdr_to_sdr_pixel_tone_map_top verification clean");
    end else begin
      $display("hdr_to_sdr_pixel_tone_map_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/hdrtm_pkg.sv
rtl/core/hdrtm_chan.sv
rtl/core/hdr_to_sdr_pixel_tone_map_top.sv
dv/hdrtm_checker.sv
dv/hdr_to_sdr_pixel_tone_map_top_test.sv
